// ===== rtl/atsw_pkg.sv =====
package atsw_pkg;

  localparam int unsigned MAX_SPAN    = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_SPAN + 1);
  localparam int unsigned INT_BITS    = 16;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COL_W       = 16;
  localparam int unsigned SHIFT_W     = 6;
  localparam int unsigned TEXEL_W     = WORD_BITS + 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_U_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_U_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_MASK  = 2'd3;

  localparam logic [SHIFT_W-1:0]   U_SHIFT_RST = 6'd16;
  localparam logic [WORD_BITS-1:0] U_MASK_RST  = 32'h0000_00FF;
  localparam logic [SHIFT_W-1:0]   V_SHIFT_RST = 6'd8;
  localparam logic [WORD_BITS-1:0] V_MASK_RST  = 32'h0000_FF00;

  typedef struct packed {
    logic [SHIFT_W-1:0]   u_shift;
    logic [WORD_BITS-1:0] u_mask;
    logic [SHIFT_W-1:0]   v_shift;
    logic [WORD_BITS-1:0] v_mask;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [WORD_BITS-1:0] u;
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] du;
    logic [WORD_BITS-1:0] dv;
    logic [CNT_W-1:0]     n;
    logic                 clip;
  } span_desc_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MULU = 4'b0010,
    S_MULV = 4'b0100,
    S_PUSH = 4'b1000
  } front_state_e;

endpackage

// ===== rtl/atsw_if.sv =====
interface atsw_span_if;
  logic                           valid;
  logic                           ready;
  logic [atsw_pkg::WORD_BITS-1:0] edge_a_x;
  logic [atsw_pkg::WORD_BITS-1:0] edge_a_u;
  logic [atsw_pkg::WORD_BITS-1:0] edge_a_v;
  logic [atsw_pkg::WORD_BITS-1:0] edge_b_x;
  logic [atsw_pkg::WORD_BITS-1:0] edge_b_u;
  logic [atsw_pkg::WORD_BITS-1:0] edge_b_v;
  logic [atsw_pkg::ROW_W-1:0]     row;
  logic signed [atsw_pkg::WORD_BITS-1:0] recip;

  modport source (output valid, edge_a_x, edge_a_u, edge_a_v, edge_b_x, edge_b_u, edge_b_v,
                  row, recip, input ready);
  modport sink (input valid, edge_a_x, edge_a_u, edge_a_v, edge_b_x, edge_b_u, edge_b_v,
                row, recip, output ready);
endinterface

interface atsw_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [atsw_pkg::ROW_W-1:0]   out_row;
  logic [atsw_pkg::COL_W-1:0]   column;
  logic [atsw_pkg::TEXEL_W-1:0] texel_index;
  logic                         last;
  logic                         clipped;

  modport source (output valid, out_row, column, texel_index, last, clipped, input ready);
  modport sink (input valid, out_row, column, texel_index, last, clipped, output ready);
endinterface

// ===== rtl/atsw_front.sv =====
module atsw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  atsw_span_if.sink            span_in,
  output logic                 push_o,
  input  logic                 full_i,
  output atsw_pkg::span_desc_t desc_o
);

  atsw_pkg::front_state_e state_q, state_d;

  logic [atsw_pkg::WORD_BITS-1:0] diff_u_q, diff_v_q, recip_q;
  logic [atsw_pkg::WORD_BITS-1:0] mul_a;
  logic signed [2*atsw_pkg::WORD_BITS-1:0] prod;
  atsw_pkg::span_desc_t desc_q;

  logic                           a_first, accept;
  logic [atsw_pkg::WORD_BITS-1:0] sx, ex, su, eu, sv, ev;
  logic [atsw_pkg::COL_W-1:0]     count;
  logic                           clip;

  assign span_in.ready = (state_q == atsw_pkg::S_IDLE);
  assign accept        = span_in.valid && span_in.ready;

  always_comb begin
    a_first = span_in.edge_a_x < span_in.edge_b_x;
    sx = a_first ? span_in.edge_a_x : span_in.edge_b_x;
    su = a_first ? span_in.edge_a_u : span_in.edge_b_u;
    sv = a_first ? span_in.edge_a_v : span_in.edge_b_v;
    ex = a_first ? span_in.edge_b_x : span_in.edge_a_x;
    eu = a_first ? span_in.edge_b_u : span_in.edge_a_u;
    ev = a_first ? span_in.edge_b_v : span_in.edge_a_v;
    count = ex[atsw_pkg::WORD_BITS-1:atsw_pkg::INT_BITS]
          - sx[atsw_pkg::WORD_BITS-1:atsw_pkg::INT_BITS];
    clip = count > atsw_pkg::COL_W'(atsw_pkg::MAX_SPAN);
  end

  assign mul_a = (state_q == atsw_pkg::S_MULU) ? diff_u_q : diff_v_q;
  assign prod  = $signed(mul_a) * $signed(recip_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      atsw_pkg::S_IDLE: begin
        if (accept && (count != '0)) begin
          state_d = atsw_pkg::S_MULU;
        end
      end
      atsw_pkg::S_MULU: state_d = atsw_pkg::S_MULV;
      atsw_pkg::S_MULV: state_d = atsw_pkg::S_PUSH;
      atsw_pkg::S_PUSH: begin
        if (!full_i) begin
          state_d = atsw_pkg::S_IDLE;
        end
      end
      default: state_d = atsw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atsw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q.row  <= span_in.row;
      desc_q.col  <= sx[atsw_pkg::WORD_BITS-1:atsw_pkg::INT_BITS];
      desc_q.u    <= su;
      desc_q.v    <= sv;
      desc_q.clip <= clip;
      desc_q.n    <= clip ? atsw_pkg::CNT_W'(atsw_pkg::MAX_SPAN) : count[atsw_pkg::CNT_W-1:0];
      diff_u_q    <= eu - su;
      diff_v_q    <= ev - sv;
      recip_q     <= span_in.recip;
    end
    if (state_q == atsw_pkg::S_MULU) begin
      desc_q.du <= prod[2*atsw_pkg::WORD_BITS-1:atsw_pkg::WORD_BITS];
    end
    if (state_q == atsw_pkg::S_MULV) begin
      desc_q.dv <= prod[2*atsw_pkg::WORD_BITS-1:atsw_pkg::WORD_BITS];
    end
  end

  assign push_o = (state_q == atsw_pkg::S_PUSH) && !full_i;
  assign desc_o = desc_q;

endmodule

// ===== rtl/atsw_queue.sv =====
module atsw_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  atsw_pkg::span_desc_t desc_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output atsw_pkg::span_desc_t desc_o
);

  atsw_pkg::span_desc_t mem_q [atsw_pkg::QUEUE_DEPTH];
  logic [atsw_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [atsw_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (atsw_pkg::QPTR_W + 1)'(atsw_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign desc_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/atsw_back.sv =====
module atsw_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atsw_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  atsw_pkg::span_desc_t desc_i,
  output logic                 pop_o,
  atsw_pixel_if.source         pix_out
);

  logic                           busy_q;
  logic [atsw_pkg::ROW_W-1:0]     row_q;
  logic [atsw_pkg::COL_W-1:0]     col_q;
  logic [atsw_pkg::WORD_BITS-1:0] u_q, v_q, du_q, dv_q;
  logic [atsw_pkg::CNT_W-1:0]     rem_q;
  logic                           clip_q;

  logic                           ov_q;
  logic [atsw_pkg::ROW_W-1:0]     o_row_q;
  logic [atsw_pkg::COL_W-1:0]     o_col_q;
  logic [atsw_pkg::TEXEL_W-1:0]   o_texel_q;
  logic                           o_last_q, o_clip_q;

  logic                           emit, last_pix, load;
  logic [atsw_pkg::WORD_BITS-1:0] tu, tv;

  assign emit     = busy_q && (!ov_q || pix_out.ready);
  assign last_pix = rem_q == atsw_pkg::CNT_W'(1);
  assign load     = valid_i && (!busy_q || (emit && last_pix));
  assign pop_o    = load;

  assign tu = (cfg_i.u_shift[atsw_pkg::SHIFT_W-1] ? '0 : (u_q >> cfg_i.u_shift[4:0]))
            & cfg_i.u_mask;
  assign tv = (cfg_i.v_shift[atsw_pkg::SHIFT_W-1] ? '0 : (v_q >> cfg_i.v_shift[4:0]))
            & cfg_i.v_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && last_pix) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (pix_out.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q  <= desc_i.row;
      col_q  <= desc_i.col;
      u_q    <= desc_i.u;
      v_q    <= desc_i.v;
      du_q   <= desc_i.du;
      dv_q   <= desc_i.dv;
      rem_q  <= desc_i.n;
      clip_q <= desc_i.clip;
    end else if (emit) begin
      col_q <= col_q + 1'b1;
      u_q   <= u_q + du_q;
      v_q   <= v_q + dv_q;
      rem_q <= rem_q - 1'b1;
    end
    if (emit) begin
      o_row_q   <= row_q;
      o_col_q   <= col_q;
      o_texel_q <= {1'b0, tu} + {1'b0, tv};
      o_last_q  <= last_pix;
      o_clip_q  <= clip_q;
    end
  end

  assign pix_out.valid       = ov_q;
  assign pix_out.out_row     = o_row_q;
  assign pix_out.column      = o_col_q;
  assign pix_out.texel_index = o_texel_q;
  assign pix_out.last        = o_last_q;
  assign pix_out.clipped     = o_clip_q;

endmodule

// ===== rtl/affine_texture_span_walker.sv =====
// Flow: an accepted span passes through the S_MULU, S_MULV and S_PUSH states into the span
// queue; the back end then loads it and registers its first pixel on the output.
// Throughput: the front end takes no new span until the current one is pushed (one signed
// 32x32 multiplier computes du and dv in turn) and S_PUSH waits while the queue is full; the
// walker emits one pixel per cycle unless the output stalls; empty spans never reach the queue.
// Reset: asynchronous, active low; config registers take their defaults and the queue empties.
module affine_texture_span_walker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  atsw_span_if.sink                           span_in,
  atsw_pixel_if.source                        pix_out,
  input  logic                                cfg_we_i,
  input  logic [atsw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [atsw_pkg::WORD_BITS-1:0]      cfg_data_i
);

  atsw_pkg::cfg_t       cfg_q;
  atsw_pkg::span_desc_t front_desc, queue_desc;
  logic                 push, full, pop, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.u_shift <= atsw_pkg::U_SHIFT_RST;
      cfg_q.u_mask  <= atsw_pkg::U_MASK_RST;
      cfg_q.v_shift <= atsw_pkg::V_SHIFT_RST;
      cfg_q.v_mask  <= atsw_pkg::V_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atsw_pkg::REG_U_SHIFT: cfg_q.u_shift <= cfg_data_i[atsw_pkg::SHIFT_W-1:0];
        atsw_pkg::REG_U_MASK:  cfg_q.u_mask  <= cfg_data_i;
        atsw_pkg::REG_V_SHIFT: cfg_q.v_shift <= cfg_data_i[atsw_pkg::SHIFT_W-1:0];
        atsw_pkg::REG_V_MASK:  cfg_q.v_mask  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  atsw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .span_in (span_in),
    .push_o  (push),
    .full_i  (full),
    .desc_o  (front_desc)
  );

  atsw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (queue_desc)
  );

  atsw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .desc_i  (queue_desc),
    .pop_o   (pop),
    .pix_out (pix_out)
  );

endmodule

// ===== rtl/atsw_checker.sv =====
module atsw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [atsw_pkg::ROW_W-1:0]   out_row,
  input logic [atsw_pkg::COL_W-1:0]   column,
  input logic [atsw_pkg::TEXEL_W-1:0] texel_index,
  input logic                         last,
  input logic                         clipped
);

  logic                       fire;
  logic                       have_q, last_q, clip_q;
  logic [atsw_pkg::ROW_W-1:0] row_q;
  logic [atsw_pkg::COL_W-1:0] col_q;

  assign fire = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      last_q <= 1'b1;
      clip_q <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (fire) begin
      have_q <= 1'b1;
      last_q <= last;
      clip_q <= clipped;
      row_q  <= out_row;
      col_q  <= column;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(texel_index) && $stable(column) && $stable(last))
    else $error("pixel payload changed while stalled");

  a_column_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && have_q && !last_q |-> column == col_q + 1'b1 && out_row == row_q)
    else $error("pixel column or row broke within a span");

  a_clip_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && have_q && !last_q |-> clipped == clip_q)
    else $error("clipped flag changed within a span");

endmodule

bind affine_texture_span_walker atsw_checker u_atsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_row     (pix_out.out_row),
  .column      (pix_out.column),
  .texel_index (pix_out.texel_index),
  .last        (pix_out.last),
  .clipped     (pix_out.clipped)
);
